FILE: rtl/ecc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecc_pkg
// shared constants and types for the eigenvector certainty colormap
// ----------------------------------------------------------------------------
package ecc_pkg;

    // q30 values up to and including 1.0
    localparam int                Q30_W    = 31;
    localparam logic [Q30_W-1:0]  Q30_ONE  = 31'h4000_0000;

    // quarter-turn fraction in q24, up to and including 1.0
    localparam int                U_W      = 25;
    localparam logic [U_W-1:0]    U_ONE    = 25'h100_0000;

    // restoring divider: 39 quotient bits, 4 per stage
    localparam int                DIV_Q_W    = 39;
    localparam int                DIV_STEPS  = 4;
    localparam int                DIV_STAGES = (DIV_Q_W + DIV_STEPS - 1) / DIV_STEPS;

    // gain in q16, capped
    localparam int                GAIN_W   = 39;
    localparam logic [GAIN_W-1:0] GAIN_CAP = 39'h40_0000_0000;

    // quarter sine polynomial, innermost coefficient first
    localparam int                SINE_TERMS = 5;
    localparam logic [Q30_W-1:0]  SINE_C [SINE_TERMS] = '{
        31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
    };

    // vector select codes
    localparam logic [1:0] VSEL_SMALL  = 2'd0;
    localparam logic [1:0] VSEL_MIDDLE = 2'd1;
    localparam logic [1:0] VSEL_LARGE  = 2'd2;

    // register index
    localparam logic REG_VSEL = 1'b0;
    localparam logic REG_MAX  = 1'b1;

    typedef struct packed {
        logic l2_zero;
        logic d3_zero;
        logic d2_zero;
        logic neg1;
        logic neg2;
        logic gain_ovf;
    } t_side;

    typedef struct packed {
        logic [Q30_W-1:0] x;
        logic [Q30_W-1:0] y;
        logic [Q30_W-1:0] z;
    } t_dir;

endpackage
`default_nettype wire

FILE: rtl/ecc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecc_div
// pipelined restoring divider, a few quotient bits per stage
// ----------------------------------------------------------------------------
module ecc_div #(
    parameter int W = 34
) (
    input  wire logic                        i_clk,
    input  wire logic [W-1:0]                i_r0,
    input  wire logic [W-1:0]                i_d,
    input  wire logic [ecc_pkg::DIV_Q_W-2:0] i_low,
    output logic      [ecc_pkg::DIV_Q_W-1:0] o_q
);
    import ecc_pkg::*;

    logic [W-1:0]         r_r   [DIV_STAGES];
    logic [W-1:0]         r_d   [DIV_STAGES];
    logic [DIV_Q_W-2:0]   r_low [DIV_STAGES];
    logic [DIV_Q_W-1:0]   r_q   [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [W-1:0]       src_r;
        logic [W-1:0]       src_d;
        logic [DIV_Q_W-2:0] src_low;
        logic [DIV_Q_W-1:0] src_q;
        logic [W-1:0]       n_r;
        logic [DIV_Q_W-2:0] n_low;
        logic [DIV_Q_W-1:0] n_q;
        logic               c_b;

        if (s == 0) begin : g_first
            assign src_r   = i_r0;
            assign src_d   = i_d;
            assign src_low = i_low;
            assign src_q   = '0;
        end else begin : g_next
            assign src_r   = r_r[s-1];
            assign src_d   = r_d[s-1];
            assign src_low = r_low[s-1];
            assign src_q   = r_q[s-1];
        end

        always_comb begin
            n_r   = src_r;
            n_low = src_low;
            n_q   = src_q;
            c_b   = 1'b0;
            for (int j = 0; j < DIV_STEPS; j++) begin
                if (s * DIV_STEPS + j < DIV_Q_W) begin
                    // remainder stays below twice the divisor
                    c_b = (n_r >= src_d);
                    if (c_b) begin
                        n_r = n_r - src_d;
                    end
                    n_r   = {n_r[W-2:0], n_low[DIV_Q_W-2]};
                    n_low = n_low << 1;
                    n_q   = {n_q[DIV_Q_W-2:0], c_b};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_r[s]   <= n_r;
            r_d[s]   <= src_d;
            r_low[s] <= n_low;
            r_q[s]   <= n_q;
        end
    end

    assign o_q = r_q[DIV_STAGES-1];

endmodule
`default_nettype wire

FILE: rtl/ecc_sine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecc_sine
// pipelined quarter sine, q24 fraction of a quarter turn in, q30 out
// ----------------------------------------------------------------------------
module ecc_sine (
    input  wire logic                      i_clk,
    input  wire logic [ecc_pkg::U_W-1:0]   i_u,
    output logic      [ecc_pkg::Q30_W-1:0] o_s
);
    import ecc_pkg::*;

    logic [Q30_W-1:0]   r_u  [SINE_TERMS];
    logic [Q30_W-1:0]   r_sq [SINE_TERMS];
    logic [Q30_W-1:0]   r_t  [SINE_TERMS];
    logic [Q30_W-1:0]   r_s;
    logic [Q30_W-1:0]   n_u0;
    logic [2*Q30_W-1:0] n_sq0;
    logic [2*Q30_W-1:0] n_s;

    assign n_u0  = {i_u, 6'd0};
    assign n_sq0 = (2*Q30_W)'(n_u0) * (2*Q30_W)'(n_u0);

    always_ff @(posedge i_clk) begin
        r_u[0]  <= n_u0;
        r_sq[0] <= n_sq0[2*Q30_W-2:30];
        r_t[0]  <= SINE_C[0];
    end

    // horner steps, one multiply per stage
    for (genvar k = 1; k < SINE_TERMS; k++) begin : g_horner
        logic [2*Q30_W-1:0] c_p;
        assign c_p = (2*Q30_W)'(r_sq[k-1]) * (2*Q30_W)'(r_t[k-1]);
        always_ff @(posedge i_clk) begin
            r_u[k]  <= r_u[k-1];
            r_sq[k] <= r_sq[k-1];
            r_t[k]  <= SINE_C[k] - c_p[2*Q30_W-2:30];
        end
    end

    assign n_s = (2*Q30_W)'(r_u[SINE_TERMS-1]) * (2*Q30_W)'(r_t[SINE_TERMS-1]);

    always_ff @(posedge i_clk) begin
        r_s <= (n_s[2*Q30_W-2:30] > Q30_ONE) ? Q30_ONE : n_s[2*Q30_W-2:30];
    end

    assign o_s = r_s;

endmodule
`default_nettype wire

FILE: rtl/eigenvector_certainty_colormap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eigenvector_certainty_colormap
// voxel eigenvalues and eigenvector angles to a certainty-blended rgb color
// ----------------------------------------------------------------------------
// o_valid follows start down a valid chain whose length is set by the 10-stage divider
// throughput: one word per cycle, busy never rises
// results are shown for one cycle on o_valid; the receiver cannot stall
// reset (synchronous, active low) empties the pipeline, vector_select = 2,
// largest_eigen_max = 1.0
module eigenvector_certainty_colormap #(
    parameter int  VALUE_WIDTH = 32,
    parameter int  ANGLE_WIDTH = 16,
    localparam int DATA_W      = (VALUE_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_W      = (VALUE_WIDTH > 32) ? 4 : 3
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [VALUE_WIDTH-1:0] i_eigen_small,
    input  wire logic signed [VALUE_WIDTH-1:0] i_eigen_middle,
    input  wire logic signed [VALUE_WIDTH-1:0] i_eigen_large,
    input  wire logic        [ANGLE_WIDTH-1:0] i_azimuth_angle,
    input  wire logic        [ANGLE_WIDTH-1:0] i_polar_angle,
    output logic                               o_valid,
    output logic             [7:0]             o_red_byte,
    output logic             [7:0]             o_green_byte,
    output logic             [7:0]             o_blue_byte,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic        [ADDR_W-1:0]      paddr,
    input  wire logic        [DATA_W-1:0]      pwdata,
    output logic             [DATA_W-1:0]      prdata,
    output logic                               pready
);
    import ecc_pkg::*;

    localparam int VW      = VALUE_WIDTH;
    localparam int RW      = VW + 2;
    localparam int GN_W    = VW + 56;
    localparam int U_SHIFT = 26 - ANGLE_WIDTH;
    localparam int LAT     = DIV_STAGES + 6;
    localparam int DIR_DLY = DIV_STAGES - 4;

    // ------------------------------------------------------------------
    // configuration
    logic [1:0]           r_vsel;
    logic signed [VW-1:0] r_max;
    logic                 c_we;
    logic                 c_idx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign c_we   = psel && penable && pwrite && pready;
    assign c_idx  = paddr[ADDR_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vsel <= VSEL_LARGE;
            r_max  <= VW'(65536);
        end else if (c_we) begin
            unique case (c_idx)
                REG_VSEL: r_vsel <= pwdata[1:0];
                REG_MAX:  r_max  <= pwdata[VW-1:0];
                default:  r_vsel <= r_vsel;
            endcase
        end
    end

    always_comb begin
        unique case (c_idx)
            REG_VSEL: prdata = DATA_W'(r_vsel);
            REG_MAX:  prdata = DATA_W'($unsigned(r_max));
            default:  prdata = '0;
        endcase
    end

    function automatic logic [VW-1:0] f_mag(input logic [VW-1:0] v);
        return v[VW-1] ? (~v + 1'b1) : v;
    endfunction

    logic [VW-1:0] c_lmax;
    logic          c_black;

    assign c_lmax  = f_mag(r_max);
    assign c_black = r_max[VW-1] || (r_max == '0);

    // ------------------------------------------------------------------
    // valid chain
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start && !busy};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: magnitudes and angle split
    logic [VW-1:0]          r_l0, r_l1, r_l2;
    logic [U_W-1:0]         r_th_s, r_th_c, r_ph_s, r_ph_c;
    logic [ANGLE_WIDTH-3:0] c_th_f, c_ph_f;
    logic [U_W-1:0]         c_th_u, c_th_w, c_ph_u, c_ph_w;
    logic                   c_th_odd, c_ph_odd;

    always_comb begin
        c_th_odd = i_azimuth_angle[ANGLE_WIDTH-2];
        c_ph_odd = i_polar_angle[ANGLE_WIDTH-2];
        c_th_f   = i_azimuth_angle[ANGLE_WIDTH-3:0];
        c_ph_f   = i_polar_angle[ANGLE_WIDTH-3:0];
        c_th_u   = U_W'(c_th_f) << U_SHIFT;
        c_ph_u   = U_W'(c_ph_f) << U_SHIFT;
        c_th_w   = U_ONE - c_th_u;
        c_ph_w   = U_ONE - c_ph_u;
    end

    always_ff @(posedge i_clk) begin
        r_l0   <= f_mag(i_eigen_small);
        r_l1   <= f_mag(i_eigen_middle);
        r_l2   <= f_mag(i_eigen_large);
        // odd quadrants swap the sine and cosine arguments
        r_th_s <= c_th_odd ? c_th_w : c_th_u;
        r_th_c <= c_th_odd ? c_th_u : c_th_w;
        r_ph_s <= c_ph_odd ? c_ph_w : c_ph_u;
        r_ph_c <= c_ph_odd ? c_ph_u : c_ph_w;
    end

    // ------------------------------------------------------------------
    // direction path
    logic [Q30_W-1:0]   w_st, w_ct, w_sp, w_cp;
    logic [2*Q30_W-1:0] c_px, c_py;
    t_dir               r_dir [DIR_DLY];

    ecc_sine u_sine_ts (.i_clk(i_clk), .i_u(r_th_s), .o_s(w_st));
    ecc_sine u_sine_tc (.i_clk(i_clk), .i_u(r_th_c), .o_s(w_ct));
    ecc_sine u_sine_ps (.i_clk(i_clk), .i_u(r_ph_s), .o_s(w_sp));
    ecc_sine u_sine_pc (.i_clk(i_clk), .i_u(r_ph_c), .o_s(w_cp));

    assign c_px = (2*Q30_W)'(w_ct) * (2*Q30_W)'(w_sp);
    assign c_py = (2*Q30_W)'(w_st) * (2*Q30_W)'(w_sp);

    always_ff @(posedge i_clk) begin
        r_dir[0].x <= c_px[2*Q30_W-2:30];
        r_dir[0].y <= c_py[2*Q30_W-2:30];
        r_dir[0].z <= w_cp;
        for (int k = 1; k < DIR_DLY; k++) begin
            r_dir[k] <= r_dir[k-1];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: sums, differences and gain setup
    logic [RW-1:0]      c_d3, c_d2;
    logic [GN_W-1:0]    c_gn;
    logic [RW-1:0]      r_n1, r_n2, r_d3, r_d2, r_gr0, r_gd;
    logic [DIV_Q_W-2:0] r_glow;
    t_side              r_side;
    t_side              r_sb [DIV_STAGES];

    assign c_d3 = RW'(r_l0) + RW'(r_l1) + RW'(r_l2);
    assign c_d2 = RW'(r_l0) + RW'(r_l1);
    assign c_gn = GN_W'(r_l2) << 16;

    always_ff @(posedge i_clk) begin
        r_n1            <= (r_l2 < r_l1) ? RW'(r_l1 - r_l2) : RW'(r_l2 - r_l1);
        r_n2            <= (r_l1 < r_l0) ? RW'(r_l0 - r_l1) : RW'(r_l1 - r_l0);
        r_d3            <= c_d3;
        r_d2            <= c_d2;
        r_gr0           <= RW'(c_gn >> 38);
        r_glow          <= c_gn[DIV_Q_W-2:0];
        r_gd            <= RW'(c_lmax);
        r_side.l2_zero  <= (r_l2 == '0);
        r_side.d3_zero  <= (c_d3 == '0);
        r_side.d2_zero  <= (c_d2 == '0);
        r_side.neg1     <= (r_l2 < r_l1);
        r_side.neg2     <= (r_l1 < r_l0);
        // quotient would not fit in 39 bits
        r_side.gain_ovf <= ((c_gn >> 39) >= GN_W'(c_lmax));
        r_sb[0]         <= r_side;
        for (int k = 1; k < DIV_STAGES; k++) begin
            r_sb[k] <= r_sb[k-1];
        end
    end

    // ------------------------------------------------------------------
    // dividers
    logic [DIV_Q_W-1:0] w_q1, w_q2, w_qg;

    ecc_div #(.W(RW)) u_div_stick (
        .i_clk(i_clk), .i_r0(r_n1), .i_d(r_d3), .i_low('0), .o_q(w_q1)
    );
    ecc_div #(.W(RW)) u_div_plate (
        .i_clk(i_clk), .i_r0(r_n2), .i_d(r_d2), .i_low('0), .o_q(w_q2)
    );
    ecc_div #(.W(RW)) u_div_gain (
        .i_clk(i_clk), .i_r0(r_gr0), .i_d(r_gd), .i_low(r_glow), .o_q(w_qg)
    );

    // ------------------------------------------------------------------
    // alpha and gain
    t_side              c_sd;
    logic signed [31:0] c_a1, c_a2, c_alpha;
    logic [GAIN_W-1:0]  c_g;
    logic signed [31:0] r_alpha;
    logic [GAIN_W-1:0]  r_g [2];

    assign c_sd = r_sb[DIV_STAGES-1];

    always_comb begin
        // ratios carry 8 extra fraction bits from their dividers
        c_a1 = $signed({1'b0, w_q1[DIV_Q_W-1:8]});
        c_a2 = $signed({1'b0, w_q2[DIV_Q_W-1:8]});
        if (c_sd.neg1) begin
            c_a1 = -c_a1;
        end
        if (c_sd.neg2) begin
            c_a2 = -c_a2;
        end
        case (r_vsel)
            VSEL_LARGE:  c_alpha = c_sd.d3_zero ? '0 : c_a1;
            VSEL_MIDDLE: c_alpha = (c_sd.d3_zero || c_sd.d2_zero) ? '0 :
                                   ((c_a1 < c_a2) ? c_a1 : c_a2);
            VSEL_SMALL:  c_alpha = c_sd.d2_zero ? '0 : c_a2;
            default:     c_alpha = $signed(32'(Q30_ONE));
        endcase
        if (c_sd.l2_zero) begin
            c_alpha = '0;
        end
        c_g = (c_sd.gain_ovf || (w_qg > GAIN_CAP)) ? GAIN_CAP : w_qg;
    end

    always_ff @(posedge i_clk) begin
        r_alpha <= c_alpha;
        r_g[0]  <= c_g;
        r_g[1]  <= r_g[0];
    end

    // ------------------------------------------------------------------
    // blend toward white
    function automatic logic [31:0] f_blend(input logic signed [31:0] a,
                                            input logic [Q30_W-1:0]   d);
        logic [Q30_W-1:0]   mag;
        logic [Q30_W-1:0]   rest;
        logic [2*Q30_W-1:0] prod;
        mag  = a[31] ? Q30_W'(-a) : Q30_W'(a);
        rest = Q30_ONE - d;
        prod = (2*Q30_W)'(mag) * (2*Q30_W)'(rest);
        return a[31] ? (32'(Q30_ONE) + 32'(prod[2*Q30_W-2:30]))
                     : (32'(Q30_ONE) - 32'(prod[2*Q30_W-2:30]));
    endfunction

    logic [31:0] r_cx, r_cy, r_cz;
    t_dir        c_dir;

    assign c_dir = r_dir[DIR_DLY-1];

    always_ff @(posedge i_clk) begin
        r_cx <= f_blend(r_alpha, c_dir.x);
        r_cy <= f_blend(r_alpha, c_dir.y);
        r_cz <= f_blend(r_alpha, c_dir.z);
    end

    // ------------------------------------------------------------------
    // gain product, then scale to bytes
    localparam int P_W = 18 + GAIN_W;

    logic [P_W-1:0] r_px, r_py, r_pz;

    always_ff @(posedge i_clk) begin
        r_px <= P_W'(r_cx[31:14]) * P_W'(r_g[1]);
        r_py <= P_W'(r_cy[31:14]) * P_W'(r_g[1]);
        r_pz <= P_W'(r_cz[31:14]) * P_W'(r_g[1]);
    end

    function automatic logic [7:0] f_byte(input logic [P_W-1:0] p);
        logic [P_W+7:0] t;
        t = {p, 8'd0} - (P_W+8)'(p);
        return (|t[P_W+7:40]) ? 8'hFF : t[39:32];
    endfunction

    logic [7:0] r_red, r_green, r_blue;

    always_ff @(posedge i_clk) begin
        r_red   <= c_black ? 8'd0 : f_byte(r_px);
        r_green <= c_black ? 8'd0 : f_byte(r_py);
        r_blue  <= c_black ? 8'd0 : f_byte(r_pz);
    end

    assign o_valid      = r_vld[LAT-1];
    assign o_red_byte   = r_red;
    assign o_green_byte = r_green;
    assign o_blue_byte  = r_blue;

    // ------------------------------------------------------------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("word out without matching start");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && c_black) |->
            (o_red_byte == 8'd0 && o_green_byte == 8'd0 && o_blue_byte == 8'd0))
        else $error("non-positive maximum must give black");

    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[DIV_STAGES+2] |->
            (r_alpha <= $signed(32'(Q30_ONE)) && r_alpha >= -$signed(32'(Q30_ONE))))
        else $error("alpha out of range");

    a_gain_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[DIV_STAGES+2] |-> (r_g[0] <= GAIN_CAP))
        else $error("gain above cap");

endmodule
`default_nettype wire

FILE: tb/sv/eigenvector_certainty_colormap_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eigenvector_certainty_colormap_test
// drives voxels through the colormap with random gaps and register changes,
// predicts each rgb word in fixed point and checks it in arrival order
// ----------------------------------------------------------------------------

class color_scoreboard;
    logic [7:0] exp_rgb [$];
    int         errors;

    function new();
        errors = 0;
    endfunction

    function void note(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        exp_rgb.push_back(r);
        exp_rgb.push_back(g);
        exp_rgb.push_back(b);
    endfunction

    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic check(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [7:0] er, eg, eb;
        if (exp_rgb.size() < 3) begin
            $display("unexpected word %0d %0d %0d at %0t", r, g, b, $realtime);
            errors++;
        end else begin
            er = exp_rgb.pop_front();
            eg = exp_rgb.pop_front();
            eb = exp_rgb.pop_front();
            if (r !== er) report("red", r, er);
            if (g !== eg) report("green", g, eg);
            if (b !== eb) report("blue", b, eb);
        end
    endtask
endclass

module eigenvector_certainty_colormap_test;
    import ecc_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic signed [31:0] i_eigen_small = '0, i_eigen_middle = '0, i_eigen_large = '0;
    logic [15:0] i_azimuth_angle = '0, i_polar_angle = '0;
    logic        o_valid;
    logic [7:0]  o_red_byte, o_green_byte, o_blue_byte;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    localparam int WATCHDOG = 20000;
    localparam int LATENCY  = 16;

    logic [1:0]  cur_vsel = VSEL_LARGE;
    logic [31:0] cur_max  = 32'd65536;
    int          idle_pct = 38;
    int          stall_cnt = 0;
    color_scoreboard sb = new();

    eigenvector_certainty_colormap u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check(o_red_byte, o_green_byte, o_blue_byte);
        if ((start && !busy) || o_valid) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt > WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] mag32(logic [31:0] v);
        return v[31] ? {32'd0, (~v) + 32'd1} : {32'd0, v};
    endfunction

    function automatic logic [63:0] qsine(logic [63:0] u24);
        logic [63:0] u, u2, t, s;
        u  = u24 << 6;
        u2 = (u * u) >> 30;
        t  = 64'd172272;
        t  = 64'd5026995 - ((u2 * t) >> 30);
        t  = 64'd85569306 - ((u2 * t) >> 30);
        t  = 64'd693598668 - ((u2 * t) >> 30);
        t  = 64'd1686629713 - ((u2 * t) >> 30);
        s  = (u * t) >> 30;
        return (s > 64'd1073741824) ? 64'd1073741824 : s;
    endfunction

    // returns {|sin|, |cos|}
    function automatic logic [127:0] sincos(logic [15:0] a);
        logic [63:0] u, w;
        u = {50'd0, a[13:0]} << 10;
        w = 64'd16777216 - u;
        if (a[14]) return {qsine(w), qsine(u)};
        return {qsine(u), qsine(w)};
    endfunction

    function automatic logic signed [63:0] sratio(logic [63:0] a, logic [63:0] b,
                                                   logic [63:0] d);
        logic [63:0] n, q, r;
        n = (a >= b) ? a - b : b - a;
        q = 0;
        r = n;
        for (int i = 0; i < 31; i++) begin
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q[0] = 1'b1;
            end
            r = r << 1;
        end
        return (a >= b) ? $signed(q) : -$signed(q);
    endfunction

    function automatic logic [7:0] shade(logic signed [63:0] alpha, logic [63:0] dir,
                                         logic [63:0] g);
        logic [63:0] m, c, v;
        m = (((alpha < 0) ? -alpha : alpha) * (64'd1073741824 - dir)) >> 30;
        c = (alpha < 0) ? 64'd1073741824 + m : 64'd1073741824 - m;
        v = ((c >> 14) * g * 64'd255) >> 32;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    task automatic predict_color(logic [31:0] e0, logic [31:0] e1, logic [31:0] e2,
                                 logic [15:0] az, logic [15:0] po);
        logic [63:0] l0, l1, l2, lm, d3, d2, g, x, y, z;
        logic [127:0] th, ph;
        logic signed [63:0] alpha, a1, a2;
        l0 = mag32(e0);
        l1 = mag32(e1);
        l2 = mag32(e2);
        lm = {32'd0, cur_max};
        if (cur_max[31] || cur_max == 0) begin
            sb.note(8'd0, 8'd0, 8'd0);
        end else begin
            th = sincos(az);
            ph = sincos(po);
            x  = (th[63:0] * ph[127:64]) >> 30;
            y  = (th[127:64] * ph[127:64]) >> 30;
            z  = ph[63:0];
            d3 = l0 + l1 + l2;
            d2 = l0 + l1;
            alpha = 64'sd1073741824;
            case (cur_vsel)
                VSEL_LARGE:  alpha = (d3 != 0) ? sratio(l2, l1, d3) : 0;
                VSEL_MIDDLE: begin
                    if (d3 == 0 || d2 == 0) alpha = 0;
                    else begin
                        a1 = sratio(l2, l1, d3);
                        a2 = sratio(l1, l0, d2);
                        alpha = (a1 < a2) ? a1 : a2;
                    end
                end
                VSEL_SMALL:  alpha = (d2 != 0) ? sratio(l1, l0, d2) : 0;
                default: ;
            endcase
            if (l2 == 0) alpha = 0;
            g = (l2 << 16) / lm;
            if (g > {25'd0, GAIN_CAP}) g = {25'd0, GAIN_CAP};
            sb.note(shade(alpha, x, g), shade(alpha, y, g), shade(alpha, z, g));
        end
    endtask

    task automatic write_reg(logic regi, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {regi, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (regi == REG_VSEL) cur_vsel = val[1:0];
        else cur_max = val;
    endtask

    task automatic drain();
        while (sb.exp_rgb.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_voxel(logic [31:0] e0, logic [31:0] e1, logic [31:0] e2,
                              logic [15:0] az, logic [15:0] po);
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_eigen_small  <= e0;
        i_eigen_middle <= e1;
        i_eigen_large  <= e2;
        i_azimuth_angle <= az;
        i_polar_angle  <= po;
        do @(posedge i_clk); while (busy);
        predict_color(e0, e1, e2, az, po);
    endtask

    function automatic logic [31:0] rand_eigen();
        case ($urandom_range(5, 0))
            0: return $urandom();
            1: return 32'sd0;
            2: return $urandom_range(65536 * 8, 0);
            3: return -$signed({16'd0, 16'($urandom())});
            default: return $urandom_range(65536 * 4, 1);
        endcase
    endfunction

    task automatic random_voxel();
        logic [31:0] a, b, c, t;
        a = rand_eigen();
        b = rand_eigen();
        c = rand_eigen();
        // mostly sorted magnitudes so the ratios stay in range
        if ($urandom_range(3, 0) != 0) begin
            a = {1'b0, a[30:0]} >> 4;
            b = {1'b0, b[30:0]} >> 4;
            c = {1'b0, c[30:0]} >> 4;
            if (a > b) begin t = a; a = b; b = t; end
            if (b > c) begin t = b; b = c; c = t; end
            if (a > b) begin t = a; a = b; b = t; end
        end
        send_voxel(a, b, c, $urandom(), $urandom());
    endtask

    initial begin
        logic [31:0] maxes [6];
        maxes = '{32'd65536, 32'h7fff_ffff, 32'd1, 32'd0, 32'h8000_0000, 32'd300000};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, zero cases, unsorted values, all selects
        for (int v = 0; v < 4; v++) begin
            write_reg(REG_VSEL, v);
            send_voxel(32'd0, 32'd0, 32'd0, 16'd0, 16'd0);
            send_voxel(32'd0, 32'd0, 32'd65536, 16'h4000, 16'h4000);
            send_voxel(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'hffff, 16'hffff);
            send_voxel(32'd65536, 32'd131072, 32'd0, 16'h2000, 16'h8000);
            send_voxel(32'd200000, 32'd100000, 32'd50000, 16'hc000, 16'h1234);
            send_voxel(32'hffff_0000, 32'd0, 32'd65536, 16'h7fff, 16'h3fff);
            // registers change only with the pipeline empty
            start <= 1'b0;
            drain();
        end

        for (int ph = 0; ph < 12; ph++) begin
            write_reg(REG_VSEL, (ph == 11) ? 2'd3 : $urandom_range(2, 0));
            write_reg(REG_MAX, (ph < 6) ? maxes[ph] : $urandom_range(1 << 20, 1));
            idle_pct = (ph == 3) ? 0 : 38;
            for (int n = 0; n < 150; n++) begin
                random_voxel();
                if (n == 75 && ph == 5) begin
                    start <= 1'b0;
                    while (sb.exp_rgb.size() != 0) @(posedge i_clk);
                end
            end
            start <= 1'b0;
            drain();
        end

        if (sb.errors == 0 && sb.exp_rgb.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
